### rtl/tft_pkg.sv
package tft_pkg;

  // Fixed field widths of the request and response transfers.
  localparam int DOC_W   = 24;
  localparam int FREQ_W  = 16;
  localparam int COUNT_W = 6;

  // Defaults for the top-level parameters.
  localparam int DEF_CAPACITY   = 32;
  localparam int DEF_ID_BITS    = 24;
  localparam int DEF_COUNT_BITS = 16;

  // Command codes.
  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_ENUM   = 2'd2;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [DOC_W-1:0] doc_id;
  } tft_in_t;

  typedef struct packed {
    logic [DOC_W-1:0]   out_doc;
    logic [FREQ_W-1:0]  frequency;
    logic [COUNT_W-1:0] doc_count;
    logic               last;
    logic               status;
  } tft_out_t;

endpackage

### rtl/tft_mem.sv
module tft_mem
  import tft_pkg::*;
#(
  parameter int DEPTH      = DEF_CAPACITY,
  parameter int ID_BITS    = DEF_ID_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we_id,
  input  logic                  we_cnt,
  input  logic [IDX_W-1:0]      wr_addr,
  input  logic [ID_BITS-1:0]    wr_id,
  input  logic [COUNT_BITS-1:0] wr_cnt,
  input  logic [IDX_W-1:0]      rd_addr,
  output logic [ID_BITS-1:0]    rd_id,
  output logic [COUNT_BITS-1:0] rd_cnt
);

  // Contents are undefined until written; only entries below the fill
  // count held by the sequencer are ever used.
  logic [ID_BITS-1:0]    ids    [DEPTH];
  logic [COUNT_BITS-1:0] counts [DEPTH];

  always_ff @(posedge clk) begin
    if (we_id) begin
      ids[wr_addr] <= wr_id;
    end
    if (we_cnt) begin
      counts[wr_addr] <= wr_cnt;
    end
  end

  always_ff @(posedge clk) begin
    rd_id  <= ids[rd_addr];
    rd_cnt <= counts[rd_addr];
  end

endmodule

### rtl/tft_unit.sv
module tft_unit
  import tft_pkg::*;
#(
  parameter int ID_BITS    = DEF_ID_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic [ID_BITS-1:0]    key,
  input  logic [ID_BITS-1:0]    id,
  input  logic [COUNT_BITS-1:0] cnt,
  output logic                  match,
  output logic [COUNT_BITS-1:0] cnt_inc
);

  // One comparator and one saturating incrementer, shared by every entry
  // visited during a scan.
  assign match   = (key == id);
  assign cnt_inc = (cnt == {COUNT_BITS{1'b1}}) ? cnt : cnt + COUNT_BITS'(1);

endmodule

### rtl/tft_seq.sv
module tft_seq
  import tft_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int ID_BITS    = DEF_ID_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  tft_in_t  req,
  output logic     res_valid,
  input  logic     res_ready,
  output tft_out_t res
);

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int USED_W = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_MISS = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]            state, state_next;
  logic [1:0]            cmd, cmd_next;
  logic [ID_BITS-1:0]    key, key_next;
  logic [IDX_W-1:0]      ptr, ptr_next;
  logic [USED_W-1:0]     used, used_next;
  tft_out_t              res_next;

  logic                  we_id, we_cnt;
  logic [IDX_W-1:0]      wr_addr;
  logic [COUNT_BITS-1:0] wr_cnt;
  logic [ID_BITS-1:0]    rd_id;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  match;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  at_end;

  tft_mem #(
    .DEPTH      (CAPACITY),
    .ID_BITS    (ID_BITS),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W)
  ) u_mem (
    .clk     (clk),
    .we_id   (we_id),
    .we_cnt  (we_cnt),
    .wr_addr (wr_addr),
    .wr_id   (key),
    .wr_cnt  (wr_cnt),
    .rd_addr (ptr),
    .rd_id   (rd_id),
    .rd_cnt  (rd_cnt)
  );

  tft_unit #(
    .ID_BITS    (ID_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_unit (
    .key     (key),
    .id      (rd_id),
    .cnt     (rd_cnt),
    .match   (match),
    .cnt_inc (cnt_inc)
  );

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_EMIT);
  assign at_end    = ((USED_W'(ptr) + USED_W'(1)) == used);

  always_comb begin
    state_next = state;
    cmd_next   = cmd;
    key_next   = key;
    ptr_next   = ptr;
    used_next  = used;
    res_next   = res;
    we_id      = 1'b0;
    we_cnt     = 1'b0;
    wr_addr    = ptr;
    wr_cnt     = cnt_inc;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd_next = req.cmd;
          key_next = ID_BITS'(req.doc_id);
          case (req.cmd) inside
            CMD_UPDATE, CMD_QUERY: begin
              ptr_next   = '0;
              state_next = (used == '0) ? S_MISS : S_RD;
            end
            CMD_ENUM: begin
              if (used != '0) begin
                ptr_next   = IDX_W'(used - USED_W'(1));
                state_next = S_RD;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_RD: begin
        state_next = S_CMP;
      end

      S_CMP: begin
        res_next.out_doc   = DOC_W'(rd_id);
        res_next.doc_count = COUNT_W'(used);
        res_next.status    = 1'b0;
        if (cmd == CMD_ENUM) begin
          res_next.frequency = FREQ_W'(rd_cnt);
          res_next.last      = (ptr == '0);
          state_next         = S_EMIT;
        end else if (match) begin
          res_next.last = 1'b1;
          if (cmd == CMD_UPDATE) begin
            we_cnt             = 1'b1;
            res_next.frequency = FREQ_W'(cnt_inc);
          end else begin
            res_next.frequency = FREQ_W'(rd_cnt);
          end
          state_next = S_EMIT;
        end else if (at_end) begin
          state_next = S_MISS;
        end else begin
          ptr_next   = ptr + IDX_W'(1);
          state_next = S_RD;
        end
      end

      S_MISS: begin
        res_next.out_doc   = DOC_W'(key);
        res_next.frequency = '0;
        res_next.last      = 1'b1;
        res_next.status    = 1'b0;
        if (cmd == CMD_UPDATE) begin
          if (used < USED_W'(CAPACITY)) begin
            we_id              = 1'b1;
            we_cnt             = 1'b1;
            wr_addr            = IDX_W'(used);
            wr_cnt             = COUNT_BITS'(1);
            used_next          = used + USED_W'(1);
            res_next.frequency = FREQ_W'(COUNT_BITS'(1));
          end else begin
            res_next.status = 1'b1;
          end
        end
        res_next.doc_count = COUNT_W'(used_next);
        state_next         = S_EMIT;
      end

      S_EMIT: begin
        if (res_ready) begin
          if (cmd == CMD_ENUM && ptr != '0) begin
            ptr_next   = ptr - IDX_W'(1);
            state_next = S_RD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
    end else begin
      state <= state_next;
      used  <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
    key <= key_next;
    ptr <= ptr_next;
    res <= res_next;
  end

endmodule

### rtl/term_frequency_table.sv
// An update or query scans the table from the oldest entry, reading each entry visited
// from memory and then comparing it; a miss then passes through the miss state, and the
// result is presented to the output register, where it then sits.
// Requests are handled one at a time; an enumerate reads and presents the listed ids in
// turn. The single read port of the entry memory and the one shared comparator make a scan visit one entry at a time.
// Reset clears the control state and the entry count; the entry memory is not cleared.
module term_frequency_table
  import tft_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int ID_BITS    = DEF_ID_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  tft_in_t  req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output tft_out_t rsp
);

  // The sequencer hands each finished result to the output register below. Because that
  // register is free whenever the downstream side takes its contents, the sequencer can
  // return to idle and accept the next transfer while an earlier result still waits.
  logic     res_valid;
  logic     res_ready;
  tft_out_t res;

  tft_seq #(
    .CAPACITY   (CAPACITY),
    .ID_BITS    (ID_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The output register loads when it is empty or its contents are being taken.
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

  // A result offered by the sequencer but not yet taken must hold until it is.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("sequencer result changed while stalled");

  // A dropped id is only reported when the table is full, with no count.
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status |->
      rsp.frequency == '0 && rsp.doc_count == COUNT_W'(CAPACITY) && rsp.last)
    else $error("drop reported on a table that is not full");

  // The sequencer takes no new request while a result of its own is pending.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !res_valid)
    else $error("request accepted while a result is pending");

endmodule
